// ----- rtl/core/wmfbm_pkg.sv -----
// Shared types and constants of the management frame BSSID monitor.
`default_nettype none

package wmfbm_pkg;

    localparam int TABLE_ENTRIES_DEF  = 32;
    localparam int ELEMENT_SCAN_LIMIT = 400;
    localparam int FIRST_ELEMENT      = 36;
    localparam int BSSID_FIRST        = 16;
    localparam int BSSID_BYTES        = 6;
    localparam int FIFO_DEPTH         = 4;

    localparam logic [11:0] OFFSET_MAX  = 12'hFFF;
    localparam logic [7:0]  TAG_RSN     = 8'd48;
    localparam logic [7:0]  TAG_VENDOR  = 8'd221;
    localparam logic [7:0]  OUI_BYTE1   = 8'h00;
    localparam logic [7:0]  OUI_BYTE2   = 8'h50;
    localparam logic [7:0]  OUI_BYTE3   = 8'hF2;
    localparam logic [3:0]  SUBTYPE_BEACON = 4'h8;
    localparam logic [3:0]  SUBTYPE_DEAUTH = 4'hC;

    localparam logic CMD_BYTE   = 1'b0;
    localparam logic CMD_READ   = 1'b1;
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    typedef enum logic [2:0] {
        ST_OTHER,
        ST_BEACON_HIT,
        ST_BEACON_NEW,
        ST_TABLE_FULL,
        ST_DEAUTH_KNOWN,
        ST_DEAUTH_UNKNOWN
    } status_t;

    typedef enum logic [1:0] {
        SEC_NONE,
        SEC_WPA1,
        SEC_WPA2
    } sec_t;

    typedef enum logic [1:0] {
        OUI_IDLE,
        OUI_WAIT1,
        OUI_WAIT2,
        OUI_WAIT3
    } oui_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_CHECK,
        BK_OUT
    } back_state_t;

    // One queued operation: a finished frame summary or an entry read.
    typedef struct packed {
        logic        cmd;
        logic        is_mgmt;
        logic [3:0]  subtype;
        logic [47:0] bssid;
        logic [1:0]  security;
        logic [4:0]  sel;
    } op_t;

    typedef struct packed {
        logic        kind;
        logic [2:0]  status;
        logic [4:0]  entry;
        logic        used;
        logic [47:0] bssid;
        logic [1:0]  security;
        logic [31:0] total;
        logic [31:0] beacons;
        logic [31:0] deauths;
    } result_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/wmfbm_in_if.sv -----
// Input channel: frame bytes and entry read requests.
`default_nettype none

interface wmfbm_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] data_byte;
    logic       is_mgmt;
    logic       last_byte;
    logic [4:0] entry_sel;

    modport source (output valid, cmd, data_byte, is_mgmt, last_byte, entry_sel,
                    input ready);
    modport sink (input valid, cmd, data_byte, is_mgmt, last_byte, entry_sel,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/core/wmfbm_out_if.sv -----
// Output channel: frame outcomes and entry read data.
`default_nettype none

interface wmfbm_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [2:0]  status;
    logic [4:0]  entry;
    logic        used;
    logic [47:0] bssid;
    logic [1:0]  security;
    logic [31:0] total_count;
    logic [31:0] beacon_count;
    logic [31:0] deauth_count;

    modport source (output valid, kind, status, entry, used, bssid, security,
                    total_count, beacon_count, deauth_count, input ready);
    modport sink (input valid, kind, status, entry, used, bssid, security,
                  total_count, beacon_count, deauth_count, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/wlan_mgmt_frame_bssid_monitor_top.sv -----
// Top level of the 802.11 management frame BSSID monitor.
//
// The req channel carries one transaction per frame byte (cmd 0) or one
// entry read request (cmd 1). The rsp channel carries one transaction per
// last frame byte (frame outcome) and one per read (entry contents).
// The parser takes one frame byte per cycle while the operation queue has
// room. Frame summaries and reads wait in a four-deep queue for the table
// engine, which reads and checks one table entry at a time during a BSSID
// search. Other frames, misses on an empty table and reads of unused entries
// go from idle straight to the output state; a read of a used entry, and
// each entry that a search visits, pass through the read and check states.
// Frame totals come from a global frame counter, so no sweep over the
// table is needed at frame end.
// Reset clears the parser state, the queue, the fill count and the frame
// counter at once; the table needs no clearing pass.
// When the receiver stalls rsp, the engine holds its result and the queue
// fills; req then stalls once the queue is full.
`default_nettype none

module wlan_mgmt_frame_bssid_monitor_top
    import wmfbm_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    wmfbm_in_if.sink    req,
    wmfbm_out_if.source rsp
);

    logic       push;
    op_t        push_op;
    logic       pop;
    op_t        head_op;
    fifo_stat_t stat;

    wmfbm_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .full    (stat.full),
        .push    (push),
        .push_op (push_op)
    );

    wmfbm_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head_op (head_op),
        .stat    (stat)
    );

    wmfbm_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head_op (head_op),
        .empty   (stat.empty),
        .pop     (pop),
        .rsp     (rsp)
    );

endmodule

`default_nettype wire

// ----- rtl/core/wmfbm_front.sv -----
// Byte parser: captures subtype and BSSID, walks the information elements.
`default_nettype none

module wmfbm_front
    import wmfbm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    wmfbm_in_if.sink  req,
    input  wire logic full,
    output logic      push,
    output op_t       push_op
);

    logic [11:0] offset_reg, offset_next;
    logic [3:0]  sub_reg, sub_next;
    logic [47:0] bssid_reg, bssid_next;
    logic [11:0] neo_reg, neo_next;
    logic [7:0]  tag_reg, tag_next;
    oui_t        oui_reg, oui_next;
    logic        done_reg, done_next;
    sec_t        sec_reg, sec_next;
    logic [13:0] nxt;
    logic        accept;

    assign req.ready = !full;
    assign accept    = req.valid && req.ready;
    assign push      = accept && (req.cmd == CMD_READ || req.last_byte);

    always_comb
    begin
        offset_next = offset_reg;
        sub_next    = sub_reg;
        bssid_next  = bssid_reg;
        neo_next    = neo_reg;
        tag_next    = tag_reg;
        oui_next    = oui_reg;
        done_next   = done_reg;
        sec_next    = sec_reg;
        nxt = 14'(neo_reg) + 14'd2 + 14'(req.data_byte);

        if (offset_reg != OFFSET_MAX)
        begin
            offset_next = offset_reg + 12'd1;
        end
        if (offset_reg == 12'd0)
        begin
            sub_next = req.data_byte[7:4];
        end
        for (int k = 0; k < BSSID_BYTES; k++)
        begin
            if (offset_reg == 12'(BSSID_FIRST + k))
            begin
                bssid_next[8*(BSSID_BYTES-1-k) +: 8] = req.data_byte;
            end
        end

        if (offset_reg >= 12'(FIRST_ELEMENT))
        begin
            // The vendor OUI check finishes even after the walk has stopped.
            unique case (oui_reg)
                OUI_IDLE: ;
                OUI_WAIT1: oui_next = (req.data_byte == OUI_BYTE1) ? OUI_WAIT2 : OUI_IDLE;
                OUI_WAIT2: oui_next = (req.data_byte == OUI_BYTE2) ? OUI_WAIT3 : OUI_IDLE;
                OUI_WAIT3:
                begin
                    if (req.data_byte == OUI_BYTE3)
                    begin
                        sec_next  = SEC_WPA1;
                        done_next = 1'b1;
                    end
                    oui_next = OUI_IDLE;
                end
            endcase

            if (!done_next)
            begin
                if (offset_reg == neo_reg)
                begin
                    tag_next = req.data_byte;
                    if (req.data_byte == TAG_RSN)
                    begin
                        sec_next  = SEC_WPA2;
                        done_next = 1'b1;
                        oui_next  = OUI_IDLE;
                    end
                end
                else if ({1'b0, offset_reg} == ({1'b0, neo_reg} + 13'd1))
                begin
                    if (tag_reg == TAG_VENDOR)
                    begin
                        oui_next = OUI_WAIT1;
                    end
                    if (req.data_byte == 8'd0 ||
                        nxt > 14'(FIRST_ELEMENT + ELEMENT_SCAN_LIMIT))
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        neo_next = nxt[11:0];
                    end
                end
            end
        end

        push_op.cmd      = req.cmd;
        push_op.is_mgmt  = req.is_mgmt;
        push_op.subtype  = sub_next;
        push_op.bssid    = bssid_next;
        push_op.security = sec_next;
        push_op.sel      = req.entry_sel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            sub_reg    <= '0;
            bssid_reg  <= '0;
            neo_reg    <= 12'(FIRST_ELEMENT);
            tag_reg    <= '0;
            oui_reg    <= OUI_IDLE;
            done_reg   <= 1'b0;
            sec_reg    <= SEC_NONE;
        end
        else if (accept && req.cmd == CMD_BYTE)
        begin
            if (req.last_byte)
            begin
                offset_reg <= '0;
                sub_reg    <= '0;
                bssid_reg  <= '0;
                neo_reg    <= 12'(FIRST_ELEMENT);
                tag_reg    <= '0;
                oui_reg    <= OUI_IDLE;
                done_reg   <= 1'b0;
                sec_reg    <= SEC_NONE;
            end
            else
            begin
                offset_reg <= offset_next;
                sub_reg    <= sub_next;
                bssid_reg  <= bssid_next;
                neo_reg    <= neo_next;
                tag_reg    <= tag_next;
                oui_reg    <= oui_next;
                done_reg   <= done_next;
                sec_reg    <= sec_next;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/wmfbm_fifo.sv -----
// Short operation queue between the parser and the table engine.
`default_nettype none

module wmfbm_fifo
    import wmfbm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  op_t       push_op,
    input  wire logic pop,
    output op_t       head_op,
    output fifo_stat_t stat
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    op_t              mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg;

    assign stat.full  = (count_reg == (PTR_W+1)'(FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign head_op    = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !stat.full)
        begin
            mem[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !stat.full)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop && !stat.empty)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_reg + (PTR_W+1)'(push && !stat.full)
                                   - (PTR_W+1)'(pop && !stat.empty);
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/wmfbm_back.sv -----
// Table engine: BSSID search, allocation, counters and entry reads.
`default_nettype none

module wmfbm_back
    import wmfbm_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  op_t         head_op,
    input  wire logic   empty,
    output logic        pop,
    wmfbm_out_if.source rsp
);

    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    // The frame total of an entry is the global frame count minus its base.
    typedef struct packed {
        logic [47:0] bssid;
        logic [1:0]  security;
        logic [31:0] base;
        logic [31:0] beacons;
        logic [31:0] deauths;
    } rec_t;

    rec_t mem [TABLE_ENTRIES];
    rec_t rd_data_reg;

    back_state_t      state_reg, state_next;
    op_t              op_reg, op_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0]      gen_reg, gen_next;
    result_t          res_reg, res_next;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    rec_t             mem_wdata;

    logic             miss;
    op_t              op_cur;
    logic [31:0]      gen_cur;
    logic [CNT_W+4:0] idx_ext, cnt_ext, sel_ext;
    logic             relevant;

    assign idx_ext = {5'd0, idx_reg};
    assign cnt_ext = {5'd0, count_reg};
    assign sel_ext = {{CNT_W{1'b0}}, head_op.sel};
    assign relevant = head_op.is_mgmt &&
                      (head_op.subtype == SUBTYPE_BEACON || head_op.subtype == SUBTYPE_DEAUTH);

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        gen_next   = gen_reg;
        res_next   = res_reg;
        pop        = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = count_reg[IDX_W-1:0];
        mem_wdata  = rd_data_reg;
        miss       = 1'b0;
        op_cur     = op_reg;
        gen_cur    = gen_reg;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!empty)
                begin
                    pop     = 1'b1;
                    op_next = head_op;
                    op_cur  = head_op;
                    if (head_op.cmd == CMD_READ)
                    begin
                        if (sel_ext < cnt_ext)
                        begin
                            idx_next   = sel_ext[CNT_W-1:0];
                            state_next = BK_READ;
                        end
                        else
                        begin
                            res_next       = '0;
                            res_next.kind  = KIND_READ;
                            res_next.entry = head_op.sel;
                            state_next     = BK_OUT;
                        end
                    end
                    else
                    begin
                        gen_next = gen_reg + 32'd1;
                        gen_cur  = gen_reg + 32'd1;
                        if (!relevant)
                        begin
                            res_next          = '0;
                            res_next.kind     = KIND_FRAME;
                            res_next.status   = ST_OTHER;
                            res_next.bssid    = head_op.bssid;
                            res_next.security = head_op.security;
                            state_next        = BK_OUT;
                        end
                        else if (count_reg == '0)
                        begin
                            miss = 1'b1;
                        end
                        else
                        begin
                            idx_next   = '0;
                            state_next = BK_READ;
                        end
                    end
                end
            end
            BK_READ:
            begin
                state_next = BK_CHECK;
            end
            BK_CHECK:
            begin
                res_next.kind     = op_reg.cmd;
                res_next.entry    = idx_ext[4:0];
                res_next.used     = 1'b1;
                res_next.bssid    = rd_data_reg.bssid;
                res_next.security = rd_data_reg.security;
                res_next.total    = gen_reg - rd_data_reg.base;
                res_next.beacons  = rd_data_reg.beacons;
                res_next.deauths  = rd_data_reg.deauths;
                if (op_reg.cmd == CMD_READ)
                begin
                    res_next.status = ST_OTHER;
                    state_next      = BK_OUT;
                end
                else if (rd_data_reg.bssid == op_reg.bssid)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = idx_reg[IDX_W-1:0];
                    if (op_reg.subtype == SUBTYPE_BEACON)
                    begin
                        mem_wdata.beacons = rd_data_reg.beacons + 32'd1;
                        res_next.status   = ST_BEACON_HIT;
                    end
                    else
                    begin
                        mem_wdata.deauths = rd_data_reg.deauths + 32'd1;
                        res_next.status   = ST_DEAUTH_KNOWN;
                    end
                    res_next.beacons = mem_wdata.beacons;
                    res_next.deauths = mem_wdata.deauths;
                    state_next       = BK_OUT;
                end
                else if ((idx_reg + CNT_W'(1)) < count_reg)
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = BK_READ;
                end
                else
                begin
                    miss = 1'b1;
                end
            end
            BK_OUT:
            begin
                if (rsp.ready)
                begin
                    state_next = BK_IDLE;
                end
            end
        endcase

        if (miss)
        begin
            res_next          = '0;
            res_next.kind     = KIND_FRAME;
            res_next.bssid    = op_cur.bssid;
            res_next.security = op_cur.security;
            state_next        = BK_OUT;
            if (op_cur.subtype == SUBTYPE_BEACON)
            begin
                if (count_reg < CNT_W'(TABLE_ENTRIES))
                begin
                    // First free entry is always the fill count: entries are never freed.
                    mem_we             = 1'b1;
                    mem_waddr          = count_reg[IDX_W-1:0];
                    mem_wdata.bssid    = op_cur.bssid;
                    mem_wdata.security = op_cur.security;
                    mem_wdata.base     = gen_cur;
                    mem_wdata.beacons  = 32'd1;
                    mem_wdata.deauths  = 32'd0;
                    count_next         = count_reg + CNT_W'(1);
                    res_next.status    = ST_BEACON_NEW;
                    res_next.entry     = cnt_ext[4:0];
                    res_next.used      = 1'b1;
                    res_next.beacons   = 32'd1;
                end
                else
                begin
                    res_next.status = ST_TABLE_FULL;
                end
            end
            else
            begin
                res_next.status = ST_DEAUTH_UNKNOWN;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[idx_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            count_reg <= '0;
            gen_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            gen_reg   <= gen_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        res_reg <= res_next;
    end

    assign rsp.valid        = (state_reg == BK_OUT);
    assign rsp.kind         = res_reg.kind;
    assign rsp.status       = res_reg.status;
    assign rsp.entry        = res_reg.entry;
    assign rsp.used         = res_reg.used;
    assign rsp.bssid        = res_reg.bssid;
    assign rsp.security     = res_reg.security;
    assign rsp.total_count  = res_reg.total;
    assign rsp.beacon_count = res_reg.beacons;
    assign rsp.deauth_count = res_reg.deauths;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_ENTRIES))
        else $error("fill count beyond table size");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |-> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("fill count moved by more than one");

    a_hit_used: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_OUT && (res_reg.status == ST_BEACON_HIT ||
         res_reg.status == ST_BEACON_NEW || res_reg.status == ST_DEAUTH_KNOWN))
        |-> res_reg.used)
        else $error("entry outcome without a used entry");

    a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_OUT && !res_reg.used)
        |-> (res_reg.total == '0 && res_reg.beacons == '0 && res_reg.deauths == '0))
        else $error("counters reported for an unused entry");

endmodule

`default_nettype wire

// ----- sim/tb_wlan_mgmt_frame_bssid_monitor_top.sv -----
// Testbench for the management frame BSSID monitor: random and directed frames with a scoreboard.
`default_nettype none

module tb_wlan_mgmt_frame_bssid_monitor_top;
    import wmfbm_pkg::*;

    typedef struct {
        logic       cmd;
        logic [7:0] data_byte;
        logic       is_mgmt;
        logic       last_byte;
        logic [4:0] entry_sel;
    } req_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    wmfbm_in_if  req_ch ();
    wmfbm_out_if rsp_ch ();

    wlan_mgmt_frame_bssid_monitor_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Predictor state.
    logic [11:0] p_off;
    logic [3:0]  p_subtype;
    logic [47:0] p_bssid;
    logic [11:0] p_next_ie;
    logic [7:0]  p_tag;
    oui_t        p_oui;
    logic        p_walk_done;
    sec_t        p_sec;
    logic        tbl_used [TABLE_ENTRIES_DEF];
    logic [47:0] tbl_bssid [TABLE_ENTRIES_DEF];
    sec_t        tbl_sec [TABLE_ENTRIES_DEF];
    logic [31:0] tbl_total [TABLE_ENTRIES_DEF];
    logic [31:0] tbl_beacons [TABLE_ENTRIES_DEF];
    logic [31:0] tbl_deauths [TABLE_ENTRIES_DEF];

    req_item_t pending_reqs[$];
    result_t   expected_results[$];
    int        error_count = 0;
    int        send_idle_pct = 21;
    int        recv_idle_pct = 67;
    logic      hold_sender = 1'b0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        error_count++;
    endtask

    function automatic void clear_frame();
        p_off = '0;
        p_subtype = '0;
        p_bssid = '0;
        p_next_ie = 12'(FIRST_ELEMENT);
        p_tag = '0;
        p_oui = OUI_IDLE;
        p_walk_done = 1'b0;
        p_sec = SEC_NONE;
    endfunction

    function automatic result_t entry_contents(input int i);
        result_t r;
        r = '0;
        r.entry = 5'(i);
        r.used = tbl_used[i];
        r.bssid = tbl_used[i] ? tbl_bssid[i] : '0;
        r.security = tbl_used[i] ? tbl_sec[i] : SEC_NONE;
        r.total = tbl_total[i];
        r.beacons = tbl_beacons[i];
        r.deauths = tbl_deauths[i];
        return r;
    endfunction

    function automatic void walk_ie(input logic [11:0] off, input logic [7:0] b);
        logic [12:0] nxt;
        case (p_oui)
            OUI_WAIT1: p_oui = (b == OUI_BYTE1) ? OUI_WAIT2 : OUI_IDLE;
            OUI_WAIT2: p_oui = (b == OUI_BYTE2) ? OUI_WAIT3 : OUI_IDLE;
            OUI_WAIT3:
            begin
                if (b == OUI_BYTE3)
                begin
                    p_sec = SEC_WPA1;
                    p_walk_done = 1'b1;
                end
                p_oui = OUI_IDLE;
            end
            default: ;
        endcase
        if (p_walk_done)
            return;
        if (off == p_next_ie)
        begin
            p_tag = b;
            if (b == TAG_RSN)
            begin
                p_sec = SEC_WPA2;
                p_walk_done = 1'b1;
                p_oui = OUI_IDLE;
            end
        end
        else if ({1'b0, off} == {1'b0, p_next_ie} + 13'd1)
        begin
            nxt = {1'b0, p_next_ie} + 13'd2 + 13'(b);
            if (p_tag == TAG_VENDOR)
                p_oui = OUI_WAIT1;
            if (b == 0 || nxt - 13'(FIRST_ELEMENT) > 13'(ELEMENT_SCAN_LIMIT))
                p_walk_done = 1'b1;
            else
                p_next_ie = nxt[11:0];
        end
    endfunction

    // Returns 1 and fills r when the transaction produces a result.
    function automatic bit predict_monitor(input req_item_t it, output result_t r);
        int hit;
        status_t st;
        r = '0;
        if (it.cmd == CMD_READ)
        begin
            r = entry_contents(it.entry_sel);
            r.kind = KIND_READ;
            r.status = ST_OTHER;
            return 1;
        end
        if (p_off == 0)
            p_subtype = it.data_byte[7:4];
        if (p_off >= 16 && p_off <= 21)
            p_bssid[8 * (21 - p_off) +: 8] = it.data_byte;
        if (p_off >= FIRST_ELEMENT)
            walk_ie(p_off, it.data_byte);
        if (!it.last_byte)
        begin
            if (p_off != OFFSET_MAX)
                p_off++;
            return 0;
        end
        hit = -1;
        st = ST_OTHER;
        for (int i = 0; i < TABLE_ENTRIES_DEF; i++)
            if (tbl_used[i])
                tbl_total[i]++;
        if (it.is_mgmt)
        begin
            for (int i = 0; i < TABLE_ENTRIES_DEF; i++)
                if (hit < 0 && tbl_used[i] && tbl_bssid[i] == p_bssid)
                    hit = i;
            if (p_subtype == SUBTYPE_BEACON)
            begin
                if (hit >= 0)
                    st = ST_BEACON_HIT;
                else
                begin
                    st = ST_TABLE_FULL;
                    for (int i = 0; i < TABLE_ENTRIES_DEF; i++)
                        if (hit < 0 && !tbl_used[i])
                        begin
                            tbl_used[i] = 1'b1;
                            tbl_bssid[i] = p_bssid;
                            tbl_sec[i] = p_sec;
                            hit = i;
                            st = ST_BEACON_NEW;
                        end
                end
                if (hit >= 0)
                    tbl_beacons[hit]++;
            end
            else if (p_subtype == SUBTYPE_DEAUTH)
            begin
                if (hit >= 0)
                begin
                    tbl_deauths[hit]++;
                    st = ST_DEAUTH_KNOWN;
                end
                else
                    st = ST_DEAUTH_UNKNOWN;
            end
        end
        if (st == ST_BEACON_HIT || st == ST_BEACON_NEW || st == ST_DEAUTH_KNOWN)
            r = entry_contents(hit);
        else
        begin
            r.bssid = p_bssid;
            r.security = p_sec;
        end
        r.kind = KIND_FRAME;
        r.status = st;
        clear_frame();
        return 1;
    endfunction

    // Driver: presents queued items, idling at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.cmd <= CMD_BYTE;
            req_ch.data_byte <= '0;
            req_ch.is_mgmt <= 1'b0;
            req_ch.last_byte <= 1'b0;
            req_ch.entry_sel <= '0;
        end
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (pending_reqs.size() != 0 && !hold_sender
                && $urandom_range(99) >= send_idle_pct)
            begin
                req_item_t it;
                it = pending_reqs.pop_front();
                req_ch.valid <= 1'b1;
                req_ch.cmd <= it.cmd;
                req_ch.data_byte <= it.data_byte;
                req_ch.is_mgmt <= it.is_mgmt;
                req_ch.last_byte <= it.last_byte;
                req_ch.entry_sel <= it.entry_sel;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor: predicts on accepted requests, checks accepted responses.
    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            req_item_t it;
            result_t r;
            it.cmd = req_ch.cmd;
            it.data_byte = req_ch.data_byte;
            it.is_mgmt = req_ch.is_mgmt;
            it.last_byte = req_ch.last_byte;
            it.entry_sel = req_ch.entry_sel;
            if (predict_monitor(it, r))
                expected_results.push_back(r);
        end
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            result_t e;
            if (expected_results.size() == 0)
            begin
                report_mismatch("response with nothing expected", 64'(rsp_ch.status), '0);
            end
            else
            begin
                e = expected_results.pop_front();
                if (rsp_ch.kind !== e.kind)
                    report_mismatch("kind", rsp_ch.kind, e.kind);
                if (rsp_ch.status !== e.status)
                    report_mismatch("status", rsp_ch.status, e.status);
                if (rsp_ch.entry !== e.entry)
                    report_mismatch("entry", rsp_ch.entry, e.entry);
                if (rsp_ch.used !== e.used)
                    report_mismatch("used", rsp_ch.used, e.used);
                if (rsp_ch.bssid !== e.bssid)
                    report_mismatch("bssid", rsp_ch.bssid, e.bssid);
                if (rsp_ch.security !== e.security)
                    report_mismatch("security", rsp_ch.security, e.security);
                if (rsp_ch.total_count !== e.total)
                    report_mismatch("total_count", rsp_ch.total_count, e.total);
                if (rsp_ch.beacon_count !== e.beacons)
                    report_mismatch("beacon_count", rsp_ch.beacon_count, e.beacons);
                if (rsp_ch.deauth_count !== e.deauths)
                    report_mismatch("deauth_count", rsp_ch.deauth_count, e.deauths);
            end
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic mgmt, input logic last);
        req_item_t it;
        it.cmd = CMD_BYTE;
        it.data_byte = b;
        it.is_mgmt = mgmt;
        it.last_byte = last;
        it.entry_sel = 5'($urandom_range(31));
        pending_reqs.push_back(it);
    endtask

    task automatic push_read(input logic [4:0] sel);
        req_item_t it;
        it.cmd = CMD_READ;
        it.data_byte = 8'($urandom_range(255));
        it.is_mgmt = 1'($urandom_range(1));
        it.last_byte = 1'($urandom_range(1));
        it.entry_sel = sel;
        pending_reqs.push_back(it);
    endtask

    // Builds one frame. ie_kind: 0 none, 1 RSN, 2 vendor WPA, 3 vendor other,
    // 4 random elements, 5 zero length element, 6 walk past the frame end.
    task automatic push_frame(input logic [3:0] subtype, input logic mgmt,
                              input logic [47:0] bssid, input int ie_kind,
                              input int flen);
        logic [7:0] body[$];
        body.delete();
        for (int i = 0; i < FIRST_ELEMENT; i++)
            body.push_back(8'($urandom_range(255)));
        body[0] = {subtype, 4'($urandom_range(15))};
        for (int i = 0; i < BSSID_BYTES; i++)
            body[BSSID_FIRST + i] = bssid[8 * (5 - i) +: 8];
        case (ie_kind)
            1: body = {body, 8'd0, 8'd2, 8'h41, 8'h42, TAG_RSN, 8'd2, 8'd1, 8'd0};
            2: body = {body, TAG_VENDOR, 8'd4, OUI_BYTE1, OUI_BYTE2, OUI_BYTE3, 8'd1};
            3: body = {body, TAG_VENDOR, 8'd4, OUI_BYTE1, OUI_BYTE2, 8'h11, 8'd1};
            5: body = {body, 8'd3, 8'd0, TAG_RSN, 8'd1, 8'd0};
            6: body = {body, 8'd1, 8'd200, 8'd5};
            4:
                for (int k = 0; k < 4; k++)
                begin
                    int len;
                    len = $urandom_range(6);
                    body.push_back($urandom_range(3) == 0 ? TAG_VENDOR
                                   : 8'($urandom_range(255)));
                    body.push_back(8'(len));
                    for (int j = 0; j < len; j++)
                        body.push_back($urandom_range(1) ? OUI_BYTE1 + 8'(j)
                                       : 8'($urandom_range(255)));
                end
            default: ;
        endcase
        if (flen > 0)
        begin
            while (body.size() > flen)
                void'(body.pop_back());
            while (body.size() < flen)
                body.push_back(8'($urandom_range(255)));
        end
        for (int i = 0; i < body.size(); i++)
            push_byte(body[i], mgmt, i == body.size() - 1);
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || req_ch.valid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [47:0] pick_bssid();
        return $urandom_range(3) != 0 ? 48'h0200_0000_0000 | 48'($urandom_range(40))
                                      : {16'($urandom), 32'($urandom)};
    endfunction

    initial
    begin
        int items_sent;
        clear_frame();
        for (int i = 0; i < TABLE_ENTRIES_DEF; i++)
        begin
            tbl_used[i] = 1'b0;
            tbl_bssid[i] = '0;
            tbl_sec[i] = SEC_NONE;
            tbl_total[i] = '0;
            tbl_beacons[i] = '0;
            tbl_deauths[i] = '0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: all security kinds, deauths, non-management, extremes.
        push_read(5'd0);
        push_frame(SUBTYPE_BEACON, 1'b1, 48'hFFFF_FFFF_FFFF, 1, 0);
        push_frame(SUBTYPE_BEACON, 1'b1, 48'h0000_0000_0001, 2, 0);
        push_frame(SUBTYPE_BEACON, 1'b1, 48'h0000_0000_0002, 3, 0);
        push_frame(SUBTYPE_BEACON, 1'b1, 48'h0000_0000_0003, 5, 0);
        push_frame(SUBTYPE_BEACON, 1'b1, 48'h0000_0000_0004, 6, 0);
        push_frame(SUBTYPE_BEACON, 1'b1, 48'hFFFF_FFFF_FFFF, 0, 0);
        push_frame(SUBTYPE_DEAUTH, 1'b1, 48'h0000_0000_0001, 0, 0);
        push_frame(SUBTYPE_DEAUTH, 1'b1, 48'h1234_5678_9ABC, 0, 0);
        push_frame(SUBTYPE_DEAUTH, 1'b0, 48'h0000_0000_0001, 0, 0);
        push_frame(4'h4, 1'b1, 48'h0000_0000_0001, 0, 0);
        push_frame(SUBTYPE_BEACON, 1'b1, 48'hAA00_0000_0000, 0, 1);
        push_frame(SUBTYPE_BEACON, 1'b1, 48'hAABB_CC00_0000, 0, 19);
        push_frame(4'h0, 1'b0, 48'h0, 0, 460);
        push_read(5'd1);
        push_read(5'd31);
        wait_drained();

        // The sender is held off here with a frame queued, then released.
        hold_sender = 1'b1;
        push_frame(SUBTYPE_BEACON, 1'b1, 48'h0000_0000_0001, 0, 0);
        repeat (20) @(posedge clk);
        hold_sender = 1'b0;

        items_sent = 0;
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 67 : 0;
            recv_idle_pct = (phase == 0) ? 67 : (phase == 1) ? 21 : 0;
            while (items_sent < 350 * (phase + 1))
            begin
                int before_cnt;
                int r;
                before_cnt = pending_reqs.size();
                r = $urandom_range(99);
                if (r < 15)
                    push_read(5'($urandom_range(31)));
                else if (r < 25)
                    for (int k = 0; k < 1 + $urandom_range(3); k++)
                        push_byte(8'($urandom_range(255)), 1'($urandom_range(1)),
                                  1'($urandom_range(7) == 0));
                else
                    push_frame(r < 70 ? SUBTYPE_BEACON : r < 85 ? SUBTYPE_DEAUTH
                               : 4'($urandom_range(15)),
                               1'($urandom_range(9) != 0), pick_bssid(),
                               $urandom_range(6), $urandom_range(9) == 0
                               ? $urandom_range(1, 60) : 0);
                items_sent += pending_reqs.size() - before_cnt;
                wait (pending_reqs.size() < 64);
            end
            wait_drained();
        end
        repeat (40) @(posedge clk);
        if (error_count == 0)
            $display("tb_wlan_mgmt_frame_bssid_monitor_top: clean");
        else
            $display("tb_wlan_mgmt_frame_bssid_monitor_top: errors");
        $finish;
    end

    initial
    begin
        #10000000;
        $display("tb_wlan_mgmt_frame_bssid_monitor_top: errors");
        $finish;
    end

endmodule

`default_nettype wire
